// ===== hw/rtl/mf3_pkg.sv =====
// Shared constants and types of the 3x3 median filter.
`timescale 1ns / 1ps

package mf3_pkg;

  localparam int DEFAULT_MAX_WIDTH  = 2048;
  localparam int DEFAULT_PIXEL_BITS = 16;

  localparam int CFG_BITS      = 12;
  localparam int HEIGHT_LIMIT  = 2048;
  localparam int OUT_ROW_BITS  = $clog2(HEIGHT_LIMIT);
  localparam int IN_ROW_BITS   = OUT_ROW_BITS + 1;
  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;
  localparam int WINDOW_TAPS   = 9;

  localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 12'd480;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } mf3_reg_t;

  typedef struct packed {
    logic emit;
    logic border;
    logic last;
  } mf3_tag_t;

endpackage

// ===== hw/rtl/mf3_pixel_if.sv =====
// Input channel of the median filter: one pixel word or flush word per handshake.
`timescale 1ns / 1ps

interface mf3_pixel_if import mf3_pkg::*; #(
  parameter int PIXEL_BITS = DEFAULT_PIXEL_BITS
) ();
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_value;
  logic                  flush;

  modport source (output valid, pixel_value, flush, input ready);
  modport sink (input valid, pixel_value, flush, output ready);
endinterface

// ===== hw/rtl/mf3_result_if.sv =====
// Output channel of the median filter: one filtered word per handshake.
`timescale 1ns / 1ps

interface mf3_result_if import mf3_pkg::*; #(
  parameter int PIXEL_BITS = DEFAULT_PIXEL_BITS
) ();
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] filtered_value;
  logic                  frame_last;

  modport source (output valid, filtered_value, frame_last, input ready);
  modport sink (input valid, filtered_value, frame_last, output ready);
endinterface

// ===== hw/rtl/mf3_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module mf3_ram #(
  parameter int  WIDTH = 32,
  parameter int  DEPTH = 2048,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/mf3_pos_ctrl.sv =====
// Input and output position counters and the per-word emit, border and last tags.
`timescale 1ns / 1ps

module mf3_pos_ctrl import mf3_pkg::*; #(
  parameter int  MAX_WIDTH = DEFAULT_MAX_WIDTH,
  localparam int AW        = $clog2(MAX_WIDTH),
  localparam int EW        = $clog2(MAX_WIDTH + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                clear,
  input  logic                step,
  input  logic [CFG_BITS-1:0] frame_width,
  input  logic [CFG_BITS-1:0] frame_height,
  output logic [AW-1:0]       col,
  output mf3_tag_t            tag
);

  logic [EW-1:0]           width_eff;
  logic [AW-1:0]           last_col;
  logic [OUT_ROW_BITS-1:0] last_row;

  logic [AW-1:0]           input_column, input_column_next;
  logic [IN_ROW_BITS-1:0]  input_row, input_row_next;
  logic [AW-1:0]           output_column, output_column_next;
  logic [OUT_ROW_BITS-1:0] output_row, output_row_next;

  always_comb begin
    if (frame_width == '0) begin
      width_eff = EW'(1);
    end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
      width_eff = EW'(MAX_WIDTH);
    end else begin
      width_eff = EW'(frame_width);
    end
    last_col = AW'(width_eff - EW'(1));
  end

  always_comb begin
    if (frame_height == '0) begin
      last_row = '0;
    end else if (32'(frame_height) > HEIGHT_LIMIT) begin
      last_row = OUT_ROW_BITS'(HEIGHT_LIMIT - 1);
    end else begin
      last_row = OUT_ROW_BITS'(frame_height - CFG_BITS'(1));
    end
  end

  assign col = input_column;

  always_comb begin
    tag.emit   = (input_row >= IN_ROW_BITS'(2)) ||
                 ((input_row == IN_ROW_BITS'(1)) && (input_column != '0));
    tag.border = (output_row == '0) || (output_row == last_row) ||
                 (output_column == '0) || (output_column == last_col);
    tag.last   = (output_row == last_row) && (output_column == last_col);
  end

  always_comb begin
    input_column_next  = input_column + AW'(1);
    input_row_next     = input_row;
    output_column_next = output_column;
    output_row_next    = output_row;
    if (input_column == last_col) begin
      input_column_next = '0;
      input_row_next    = input_row + IN_ROW_BITS'(1);
    end
    if (tag.emit) begin
      if (tag.last) begin
        input_column_next  = '0;
        input_row_next     = '0;
        output_column_next = '0;
        output_row_next    = '0;
      end else if (output_column == last_col) begin
        output_column_next = '0;
        output_row_next    = output_row + OUT_ROW_BITS'(1);
      end else begin
        output_column_next = output_column + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      input_column  <= '0;
      input_row     <= '0;
      output_column <= '0;
      output_row    <= '0;
    end else if (step) begin
      input_column  <= input_column_next;
      input_row     <= input_row_next;
      output_column <= output_column_next;
      output_row    <= output_row_next;
    end
  end

endmodule

// ===== hw/rtl/mf3_line_window.sv =====
// Line memory read-modify-write with forwarding, and the 3x3 window shift register.
`timescale 1ns / 1ps

module mf3_line_window import mf3_pkg::*; #(
  parameter int  MAX_WIDTH  = DEFAULT_MAX_WIDTH,
  parameter int  PIXEL_BITS = DEFAULT_PIXEL_BITS,
  localparam int AW         = $clog2(MAX_WIDTH)
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   adv,
  input  logic                                   take,
  input  logic [AW-1:0]                          col,
  input  logic [PIXEL_BITS-1:0]                  px,
  input  mf3_tag_t                               tag,
  output logic                                   win_valid,
  output mf3_tag_t                               win_tag,
  output logic [WINDOW_TAPS-1:0][PIXEL_BITS-1:0] win
);

  logic                    s1_valid;
  mf3_tag_t                s1_tag;
  logic [AW-1:0]           s1_col;
  logic [PIXEL_BITS-1:0]   s1_px;
  logic                    fwd;
  logic [2*PIXEL_BITS-1:0] fwd_data;
  logic [2*PIXEL_BITS-1:0] rdata;
  logic [PIXEL_BITS-1:0]   top;
  logic [PIXEL_BITS-1:0]   mid;

  // Each memory word holds the upper and middle line pixels of one column.
  mf3_ram #(
    .WIDTH (2 * PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_valid && adv),
    .waddr (s1_col),
    .wdata ({mid, s1_px}),
    .re    (take),
    .raddr (col),
    .rdata (rdata)
  );

  assign {top, mid} = fwd ? fwd_data : rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      win_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= take;
      win_valid <= s1_valid && s1_tag.emit;
    end
  end

  // A word read in the same cycle as the write to its column takes the written data.
  always_ff @(posedge clk) begin
    if (take) begin
      s1_tag   <= tag;
      s1_col   <= col;
      s1_px    <= px;
      fwd      <= s1_valid && (s1_col == col);
      fwd_data <= {mid, s1_px};
    end
    if (adv) begin
      win_tag <= s1_tag;
    end
    if (adv && s1_valid) begin
      for (int k = 0; k < 3; k++) begin
        win[3*k]     <= win[3*k + 1];
        win[3*k + 1] <= win[3*k + 2];
      end
      win[2] <= top;
      win[5] <= mid;
      win[8] <= s1_px;
    end
  end

endmodule

// ===== hw/rtl/mf3_median.sv =====
// Three-stage median-of-nine compare network with border pass-through select.
`timescale 1ns / 1ps

module mf3_median import mf3_pkg::*; #(
  parameter int PIXEL_BITS = DEFAULT_PIXEL_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   adv,
  input  logic                                   in_valid,
  input  mf3_tag_t                               in_tag,
  input  logic [WINDOW_TAPS-1:0][PIXEL_BITS-1:0] win,
  output logic                                   out_valid,
  output mf3_tag_t                               out_tag,
  output logic [PIXEL_BITS-1:0]                  value
);

  typedef logic [PIXEL_BITS-1:0] pix_t;

  function automatic logic [2:0][PIXEL_BITS-1:0] sort3(input pix_t a, input pix_t b,
                                                        input pix_t c);
    pix_t x0, x1, x2, t;
    x0 = a;
    x1 = b;
    x2 = c;
    if (x0 > x1) begin
      t = x0; x0 = x1; x1 = t;
    end
    if (x1 > x2) begin
      t = x1; x1 = x2; x2 = t;
    end
    if (x0 > x1) begin
      t = x0; x0 = x1; x1 = t;
    end
    return {x2, x1, x0};
  endfunction

  function automatic pix_t min2(input pix_t a, input pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(input pix_t a, input pix_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  logic                   s3_valid;
  mf3_tag_t               s3_tag;
  pix_t                   s3_center;
  logic [2:0][2:0][PIXEL_BITS-1:0] s3_rows;

  logic     s4_valid;
  mf3_tag_t s4_tag;
  pix_t     s4_center;
  pix_t     s4_lo_max;
  pix_t     s4_md_med;
  pix_t     s4_hi_min;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= in_valid;
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_tag    <= in_tag;
      s3_center <= win[4];
      for (int k = 0; k < 3; k++) begin
        s3_rows[k] <= sort3(win[3*k], win[3*k + 1], win[3*k + 2]);
      end
      s4_tag    <= s3_tag;
      s4_center <= s3_center;
      s4_lo_max <= max2(max2(s3_rows[0][0], s3_rows[1][0]), s3_rows[2][0]);
      s4_md_med <= med3(s3_rows[0][1], s3_rows[1][1], s3_rows[2][1]);
      s4_hi_min <= min2(min2(s3_rows[0][2], s3_rows[1][2]), s3_rows[2][2]);
    end
  end

  assign out_valid = s4_valid;
  assign out_tag   = s4_tag;
  assign value     = s4_tag.border ? s4_center : med3(s4_lo_max, s4_md_med, s4_hi_min);

endmodule

// ===== hw/rtl/median_filter_3x3_core.sv =====
// Streaming 3x3 median filter top level: configuration registers and output register.
// Throughput: one word per cycle in and out when the output is not stalled; the line memory does one
// read and one write a cycle. A result is registered at the output after its releasing word, which is
// accepted frame_width+1 words after its own pixel; frame_width+1 flush words drain the frame.
// Reset clears the position counters and valid bits and loads frame_width 640, frame_height 480;
// the line memory needs no clearing pass, as data read before it is written reaches no result.
`timescale 1ns / 1ps

module median_filter_3x3_core import mf3_pkg::*; #(
  parameter int  MAX_WIDTH  = DEFAULT_MAX_WIDTH,
  parameter int  PIXEL_BITS = DEFAULT_PIXEL_BITS,
  localparam int AW         = $clog2(MAX_WIDTH)
) (
  input  logic                     clk,
  input  logic                     rst,
  mf3_pixel_if.sink                pixel,
  mf3_result_if.source             result,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  logic [CFG_BITS-1:0] frame_width;
  logic [CFG_BITS-1:0] frame_height;
  logic                cfg_write;

  logic                                   adv;
  logic                                   take;
  logic [PIXEL_BITS-1:0]                  px;
  logic [AW-1:0]                          col;
  mf3_tag_t                               tag;
  logic                                   win_valid;
  mf3_tag_t                               win_tag;
  logic [WINDOW_TAPS-1:0][PIXEL_BITS-1:0] win;
  logic                                   med_valid;
  mf3_tag_t                               med_tag;
  logic [PIXEL_BITS-1:0]                  med_value;

  logic                  out_valid;
  logic [PIXEL_BITS-1:0] out_value;
  logic                  out_last;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (mf3_reg_t'(paddr[2]))
        REG_FRAME_WIDTH:  frame_width  <= pwdata[CFG_BITS-1:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[CFG_BITS-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (mf3_reg_t'(paddr[2]))
      REG_FRAME_WIDTH:  prdata = APB_DATA_BITS'(frame_width);
      REG_FRAME_HEIGHT: prdata = APB_DATA_BITS'(frame_height);
    endcase
  end

  // The pipeline moves unless a result word is at its end and the output register is stuck.
  assign adv         = !med_valid || !out_valid || result.ready;
  assign take        = pixel.valid && adv;
  assign pixel.ready = adv;
  assign px          = pixel.flush ? '0 : pixel.pixel_value;

  mf3_pos_ctrl #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_pos_ctrl (
    .clk          (clk),
    .rst          (rst),
    .clear        (cfg_write),
    .step         (take),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .col          (col),
    .tag          (tag)
  );

  mf3_line_window #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_line_window (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .take      (take),
    .col       (col),
    .px        (px),
    .tag       (tag),
    .win_valid (win_valid),
    .win_tag   (win_tag),
    .win       (win)
  );

  mf3_median #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_median (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (win_valid),
    .in_tag    (win_tag),
    .win       (win),
    .out_valid (med_valid),
    .out_tag   (med_tag),
    .value     (med_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && med_valid) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && med_valid) begin
      out_value <= med_value;
      out_last  <= med_tag.last;
    end
  end

  assign result.valid          = out_valid;
  assign result.filtered_value = out_value;
  assign result.frame_last     = out_last;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench of the 3x3 median filter core with a window predictor and APB setup.
`timescale 1ns / 1ps

import mf3_pkg::*;

typedef logic [DEFAULT_PIXEL_BITS-1:0] pixel_t;

class median_scoreboard;
  typedef struct {
    pixel_t value;
    logic   last;
  } filtered_t;

  logic [CFG_BITS-1:0] width_reg;
  logic [CFG_BITS-1:0] height_reg;
  pixel_t              upper_line [DEFAULT_MAX_WIDTH];
  pixel_t              middle_line [DEFAULT_MAX_WIDTH];
  pixel_t              window [WINDOW_TAPS];
  int                  in_col;
  int                  in_row;
  int                  out_col;
  int                  out_row;
  filtered_t           expected_filtered [$];
  int                  mismatches;

  function new();
    width_reg  = WIDTH_RESET;
    height_reg = HEIGHT_RESET;
    foreach (upper_line[i]) begin
      upper_line[i]  = '0;
      middle_line[i] = '0;
    end
    foreach (window[i]) window[i] = '0;
    mismatches = 0;
    clear_position();
  endfunction

  function void clear_position();
    in_col  = 0;
    in_row  = 0;
    out_col = 0;
    out_row = 0;
  endfunction

  function int clamp_dim(logic [CFG_BITS-1:0] raw, int limit);
    if (raw == 0) return 1;
    if (raw > limit) return limit;
    return raw;
  endfunction

  function void set_reg(mf3_reg_t idx, logic [CFG_BITS-1:0] val);
    if (idx == REG_FRAME_WIDTH) width_reg = val;
    else height_reg = val;
    clear_position();
  endfunction

  function pixel_t window_median();
    pixel_t ranked [$];
    foreach (window[i]) ranked.push_back(window[i]);
    ranked.sort();
    return ranked[4];
  endfunction

  // Shifts one word into the line stores and the window, and queues the output it releases.
  function void take_pixel(pixel_t raw, logic flush);
    int        w;
    int        h;
    int        col;
    int        row;
    int        slot;
    pixel_t    px;
    pixel_t    top;
    pixel_t    mid;
    pixel_t    wrap;
    filtered_t item;
    w    = clamp_dim(width_reg, DEFAULT_MAX_WIDTH);
    h    = clamp_dim(height_reg, HEIGHT_LIMIT);
    px   = flush ? '0 : raw;
    col  = in_col;
    row  = in_row;
    slot = col % DEFAULT_MAX_WIDTH;
    wrap = window[5];
    top  = upper_line[slot];
    mid  = middle_line[slot];
    upper_line[slot]  = mid;
    middle_line[slot] = px;
    for (int k = 0; k < 3; k++) begin
      window[k*3]   = window[k*3+1];
      window[k*3+1] = window[k*3+2];
    end
    window[2] = top;
    window[5] = mid;
    window[8] = px;
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (!(row >= 2 || (row == 1 && col >= 1))) return;
    item.last = (out_row == h - 1) && (out_col == w - 1);
    if (col == 0) item.value = wrap;
    else if (out_row == 0 || out_row == h - 1 || out_col == 0 || out_col == w - 1)
      item.value = window[4];
    else item.value = window_median();
    expected_filtered.push_back(item);
    if (item.last) begin
      clear_position();
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
  endfunction

  task report(string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task check_output(pixel_t value, logic last);
    filtered_t want;
    if (expected_filtered.size() == 0) begin
      report($sformatf("output word %h with none expected", value));
      return;
    end
    want = expected_filtered.pop_front();
    if (value !== want.value)
      report($sformatf("filtered_value %h, expected %h", value, want.value));
    if (last !== want.last)
      report($sformatf("frame_last %b, expected %b", last, want.last));
  endtask

  function int pending();
    return expected_filtered.size();
  endfunction
endclass

module tb;
  localparam int SETTLE_CYCLES = 12;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_WORDS  = 1200;
  localparam int CORNERS       = 8;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  mf3_pixel_if  pix_if ();
  mf3_result_if res_if ();

  median_scoreboard board = new();

  int quiet_cycles = 0;
  int random_words = 0;
  bit send_calm    = 1'b0;
  bit take_calm    = 1'b0;

  int corner_w [CORNERS] = '{0, 1, 2, 6, 3, 2, 1, 3};
  int corner_h [CORNERS] = '{7, 3, 1, 0, 4, 2, 1, 2};

  median_filter_3x3_core DUT (
    .clk,
    .rst,
    .pixel  (pix_if),
    .result (res_if),
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  always #5 clk = ~clk;

  function automatic int draw_gap(inout bit calm);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 5);
  endfunction

  function automatic pixel_t random_pixel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return pixel_t'(16'h8000 + $urandom_range(0, 3));
      default: return pixel_t'($urandom);
    endcase
  endfunction

  task automatic send_word(input pixel_t value, input logic flush);
    int gap;
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_if.valid       <= 1'b1;
    pix_if.pixel_value <= value;
    pix_if.flush       <= flush;
    do @(posedge clk); while (!pix_if.ready);
    board.take_pixel(value, flush);
  endtask

  task automatic wait_drained();
    pix_if.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_xfer(input bit wr, input mf3_reg_t idx, input logic [CFG_BITS-1:0] val,
                          output logic [APB_DATA_BITS-1:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= {20'($urandom), val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
  endtask

  task automatic check_regs();
    logic [APB_DATA_BITS-1:0] rd;
    apb_xfer(1'b0, REG_FRAME_WIDTH, '0, rd);
    if (rd[CFG_BITS-1:0] !== board.width_reg)
      board.report($sformatf("frame_width reads %h, expected %h", rd, board.width_reg));
    apb_xfer(1'b0, REG_FRAME_HEIGHT, '0, rd);
    if (rd[CFG_BITS-1:0] !== board.height_reg)
      board.report($sformatf("frame_height reads %h, expected %h", rd, board.height_reg));
  endtask

  task automatic program_frame(input int w_raw, input int h_raw);
    logic [APB_DATA_BITS-1:0] rd;
    apb_xfer(1'b1, REG_FRAME_WIDTH, CFG_BITS'(w_raw), rd);
    board.set_reg(REG_FRAME_WIDTH, CFG_BITS'(w_raw));
    apb_xfer(1'b1, REG_FRAME_HEIGHT, CFG_BITS'(h_raw), rd);
    board.set_reg(REG_FRAME_HEIGHT, CFG_BITS'(h_raw));
    check_regs();
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // A cut frame stops at a random word and skips the drain, so the next words run on.
  task automatic run_frame(input bit counted, input bit cut);
    int w;
    int h;
    int total;
    w     = board.clamp_dim(board.width_reg, DEFAULT_MAX_WIDTH);
    h     = board.clamp_dim(board.height_reg, HEIGHT_LIMIT);
    total = w * h;
    if (cut) total = $urandom_range(1, total);
    for (int i = 0; i < total; i++) begin
      send_word(random_pixel(), $urandom_range(0, 19) == 0);
      if (counted) random_words++;
    end
    if (!cut) begin
      for (int i = 0; i <= w; i++) begin
        send_word(random_pixel(), $urandom_range(0, 7) != 0);
        if (counted) random_words++;
      end
    end
  endtask

  initial begin : result_sink
    int stall;
    res_if.ready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      stall = draw_gap(take_calm);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!res_if.valid);
      board.check_output(res_if.filtered_value, res_if.frame_last);
    end
  end

  always @(posedge clk) begin
    if (rst || (pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    pixel_t directed_px [16];
    logic   directed_fl [16];
    int     corner;
    int     phase;
    int     frames;
    bit     is_corner;
    rst                = 1'b1;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    pix_if.valid       = 1'b0;
    pix_if.pixel_value = '0;
    pix_if.flush       = 1'b0;
    directed_px = '{16'hFFFF, 16'h0000, 16'h8000, 16'h0001, 16'hFFFE, 16'h7FFF, 16'h1234,
                    16'hAAAA, 16'h5555, 16'h0000, 16'h0000, 16'hBEEF, 16'h0000,
                    16'hFFFF, 16'h0000, 16'h0000};
    directed_fl = '{0, 0, 0, 0, 0, 0, 1, 0, 0, 1, 1, 0, 1, 0, 1, 0};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset values, then a 3x3 frame whose single interior word tells the true median
    // from its neighbor in rank, then a zero-sized setting that acts as a 1x1 frame.
    check_regs();
    program_frame(3, 3);
    for (int i = 0; i < 13; i++) send_word(directed_px[i], directed_fl[i]);
    wait_drained();
    program_frame(0, 0);
    for (int i = 13; i < 16; i++) send_word(directed_px[i], directed_fl[i]);

    corner = 0;
    phase  = 0;
    while (random_words < RANDOM_WORDS || corner < CORNERS) begin
      wait_drained();
      is_corner = (phase % 3 == 2) && (corner < CORNERS);
      if (is_corner) begin
        program_frame(corner_w[corner], corner_h[corner]);
        corner++;
        frames = 1;
      end else begin
        program_frame($urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 12),
                      $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 10));
        frames = $urandom_range(1, 3);
      end
      for (int f = 0; f < frames; f++) begin
        run_frame(!is_corner, !is_corner && $urandom_range(0, 9) == 0);
        if ($urandom_range(0, 3) == 0) wait_drained();
      end
      phase++;
    end

    wait_drained();
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
hw/rtl/mf3_pkg.sv
hw/rtl/mf3_pixel_if.sv
hw/rtl/mf3_result_if.sv
hw/rtl/mf3_ram.sv
hw/rtl/mf3_pos_ctrl.sv
hw/rtl/mf3_line_window.sv
hw/rtl/mf3_median.sv
hw/rtl/median_filter_3x3_core.sv
tb/tb.sv
